@@ src/lavm_pkg.sv @@
// Shared types, widths and helper functions for the look-at view matrix core.
package lavm_pkg;

    localparam int WW = 32;    // Q16.16 word
    localparam int DW = 33;    // eye minus target
    localparam int NW = 50;    // unnormalized vector component
    localparam int UW = 18;    // unit component, at most 1.0
    localparam int ONE_Q16 = 65536;

    localparam logic [1:0] LAST_COL = 2'd3;

    typedef logic signed [WW-1:0] word_t;
    typedef logic signed [DW-1:0] diff_t;
    typedef logic signed [NW-1:0] vec_t;
    typedef logic signed [UW-1:0] unit_t;

    typedef word_t [2:0] word3_t;
    typedef diff_t [2:0] diff3_t;
    typedef vec_t  [2:0] vec3_t;
    typedef unit_t [2:0] unit3_t;

    typedef struct packed {
        word_t eye_x;
        word_t eye_y;
        word_t eye_z;
        word_t target_x;
        word_t target_y;
        word_t target_z;
        word_t up_x;
        word_t up_y;
        word_t up_z;
    } in_t;

    typedef struct packed {
        logic [1:0] column_index;
        word_t      row0_value;
        word_t      row1_value;
        word_t      row2_value;
        word_t      row3_value;
        logic       last_beat;
    } out_t;

    // one queued request: eye, forward direction, up
    typedef struct packed {
        word3_t eye;
        diff3_t dir;
        word3_t up;
    } item_t;

    // cross product a x b as six products, two per component, second one subtracted
    function automatic logic [1:0] cross_a_idx(input logic [2:0] s);
        logic [1:0] r;
        case (s)
            3'd0:    r = 2'd1;
            3'd1:    r = 2'd2;
            3'd2:    r = 2'd2;
            3'd3:    r = 2'd0;
            3'd4:    r = 2'd0;
            3'd5:    r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] cross_b_idx(input logic [2:0] s);
        logic [1:0] r;
        case (s)
            3'd0:    r = 2'd2;
            3'd1:    r = 2'd1;
            3'd2:    r = 2'd0;
            3'd3:    r = 2'd2;
            3'd4:    r = 2'd1;
            3'd5:    r = 2'd0;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // negate a Q18.32 dot product, round half up to Q16.16, saturate
    function automatic word_t round_sat(input vec_t s);
        logic signed [NW:0]    v;
        logic signed [NW-16:0] r;
        word_t                 q;
        v = $signed((NW+1)'(32768)) - $signed({s[NW-1], s});
        r = $signed(v[NW:16]);
        if (!r[NW-16] && (|r[NW-17:WW-1])) begin
            q = {1'b0, {(WW-1){1'b1}}};
        end else if (r[NW-16] && !(&r[NW-17:WW-1])) begin
            q = {1'b1, {(WW-1){1'b0}}};
        end else begin
            q = r[WW-1:0];
        end
        return q;
    endfunction

endpackage

@@ src/lavm_front.sv @@
// Front end: request intake, forward direction, two-entry queue to the back end.
module lavm_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  lavm_pkg::in_t    in_data,
    output logic             q_valid,
    input  logic             q_pop,
    output lavm_pkg::item_t  q_item
);

    lavm_pkg::item_t ent_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      cnt_reg;
    lavm_pkg::item_t push_item;
    logic            push;
    logic            pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;
    assign q_item   = ent_reg[rd_ptr_reg];

    always_comb
    begin
        push_item.eye = {in_data.eye_z, in_data.eye_y, in_data.eye_x};
        push_item.up  = {in_data.up_z, in_data.up_y, in_data.up_x};
        push_item.dir[0] = lavm_pkg::diff_t'(in_data.eye_x) - lavm_pkg::diff_t'(in_data.target_x);
        push_item.dir[1] = lavm_pkg::diff_t'(in_data.eye_y) - lavm_pkg::diff_t'(in_data.target_y);
        push_item.dir[2] = lavm_pkg::diff_t'(in_data.eye_z) - lavm_pkg::diff_t'(in_data.target_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                ent_reg[wr_ptr_reg] <= push_item;
                wr_ptr_reg          <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

@@ src/lavm_norm.sv @@
// Vector normalizer: block shift, sum of squares, bit-serial square root and divide.
module lavm_norm (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  lavm_pkg::vec3_t  vec,
    output logic             done,
    output lavm_pkg::unit3_t unit
);

    typedef enum logic [2:0] {
        N_IDLE, N_CHECK, N_SHIFT, N_SQ, N_SQRT, N_DIVLD, N_DIV, N_DONE
    } nstate_t;

    nstate_t                     state_reg;
    logic [lavm_pkg::NW-1:0]     a_reg [3];
    logic [2:0]                  neg_reg;
    logic [lavm_pkg::NW-1:0]     m_reg;
    logic [4:0]                  cnt_reg;
    logic [1:0]                  comp_reg;
    logic [59:0]                 p_reg;
    logic [61:0]                 sum_reg;
    logic [61:0]                 sh_reg;
    logic [32:0]                 sq_rem_reg;
    logic [30:0]                 root_reg;
    logic [30:0]                 dv_rem_reg;
    logic [17:0]                 qn_reg;
    lavm_pkg::unit3_t            unit_reg;

    logic [lavm_pkg::NW-1:0]     abs_v [3];
    logic [lavm_pkg::NW-1:0]     max01;
    logic [lavm_pkg::NW-1:0]     max_v;
    logic [29:0]                 sq_op;
    logic [59:0]                 sq_prod;
    logic [34:0]                 rem_sh;
    logic [34:0]                 trial;
    logic [46:0]                 num;
    logic [31:0]                 div_sh;
    logic                        qbit;
    logic [17:0]                 q_final;

    assign done = (state_reg == N_DONE);
    assign unit = unit_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            abs_v[i] = vec[i][lavm_pkg::NW-1] ? (~vec[i] + 1'b1) : vec[i];
        end
        max01 = (abs_v[0] > abs_v[1]) ? abs_v[0] : abs_v[1];
        max_v = (max01 > abs_v[2]) ? max01 : abs_v[2];
        sq_op   = a_reg[cnt_reg[1:0]][29:0];
        sq_prod = sq_op * sq_op;
        rem_sh  = {sq_rem_reg, sh_reg[61:60]};
        trial   = {2'b00, root_reg, 2'b01};
        num     = {1'b0, a_reg[comp_reg][29:0], 16'd0} + 47'(root_reg[30:1]);
        div_sh  = {dv_rem_reg, qn_reg[17]};
        qbit    = (div_sh >= {1'b0, root_reg});
        q_final = {qn_reg[16:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            cnt_reg   <= 5'd0;
            comp_reg  <= 2'd0;
        end
        else
        begin
            unique case (state_reg)
                N_IDLE:
                begin
                    if (start)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            a_reg[i]   <= abs_v[i];
                            neg_reg[i] <= vec[i][lavm_pkg::NW-1];
                        end
                        m_reg     <= max_v;
                        state_reg <= N_CHECK;
                    end
                end
                N_CHECK:
                begin
                    cnt_reg <= 5'd0;
                    if (m_reg == '0)
                    begin
                        unit_reg  <= '0;
                        state_reg <= N_DONE;
                    end
                    else
                    begin
                        state_reg <= N_SHIFT;
                    end
                end
                N_SHIFT:
                begin
                    // bring the largest magnitude into [2^29, 2^30)
                    if (|m_reg[lavm_pkg::NW-1:30])
                    begin
                        m_reg <= m_reg >> 1;
                        for (int i = 0; i < 3; i++) a_reg[i] <= a_reg[i] >> 1;
                    end
                    else if (!m_reg[29])
                    begin
                        m_reg <= m_reg << 1;
                        for (int i = 0; i < 3; i++) a_reg[i] <= a_reg[i] << 1;
                    end
                    else
                    begin
                        state_reg <= N_SQ;
                    end
                end
                N_SQ:
                begin
                    if (cnt_reg < 5'd3)
                    begin
                        p_reg <= sq_prod;
                    end
                    if (cnt_reg == 5'd1)
                    begin
                        sum_reg <= 62'(p_reg);
                    end
                    else if (cnt_reg == 5'd2 || cnt_reg == 5'd3)
                    begin
                        sum_reg <= sum_reg + 62'(p_reg);
                    end
                    if (cnt_reg == 5'd4)
                    begin
                        sh_reg     <= sum_reg;
                        sq_rem_reg <= '0;
                        root_reg   <= '0;
                        cnt_reg    <= 5'd0;
                        state_reg  <= N_SQRT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                N_SQRT:
                begin
                    // two radicand bits per step
                    if (rem_sh >= trial)
                    begin
                        sq_rem_reg <= 33'(rem_sh - trial);
                        root_reg   <= {root_reg[29:0], 1'b1};
                    end
                    else
                    begin
                        sq_rem_reg <= rem_sh[32:0];
                        root_reg   <= {root_reg[29:0], 1'b0};
                    end
                    sh_reg <= sh_reg << 2;
                    if (cnt_reg == 5'd30)
                    begin
                        comp_reg  <= 2'd0;
                        state_reg <= N_DIVLD;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                N_DIVLD:
                begin
                    // quotient stays below 2^18, so the top bits start as remainder
                    dv_rem_reg <= {2'b00, num[46:18]};
                    qn_reg     <= num[17:0];
                    cnt_reg    <= 5'd0;
                    state_reg  <= N_DIV;
                end
                N_DIV:
                begin
                    if (qbit)
                    begin
                        dv_rem_reg <= 31'(div_sh - {1'b0, root_reg});
                    end
                    else
                    begin
                        dv_rem_reg <= div_sh[30:0];
                    end
                    qn_reg <= q_final;
                    if (cnt_reg == 5'd17)
                    begin
                        unit_reg[comp_reg] <= neg_reg[comp_reg] ? -$signed(q_final)
                                                                : $signed(q_final);
                        if (comp_reg == 2'd2)
                        begin
                            state_reg <= N_DONE;
                        end
                        else
                        begin
                            comp_reg  <= comp_reg + 2'd1;
                            state_reg <= N_DIVLD;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                N_DONE:
                begin
                    state_reg <= N_IDLE;
                end
                default:
                begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/lavm_back.sv @@
// Back end: sequencer for the three axes, shared multiplier, result buffer and column beats.
module lavm_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_pop,
    input  lavm_pkg::item_t  q_item,
    output logic             out_valid,
    input  logic             out_ready,
    output lavm_pkg::out_t   out_data
);

    typedef enum logic [3:0] {
        B_IDLE, B_Z_GO, B_Z_WAIT, B_XR, B_X_GO, B_X_WAIT,
        B_YR, B_Y_GO, B_Y_WAIT, B_DOT, B_FIN
    } bstate_t;

    bstate_t            state_reg;
    logic [2:0]         step_reg;
    logic [1:0]         dot_reg;
    lavm_pkg::word3_t   eye_reg;
    lavm_pkg::word3_t   up_reg;
    lavm_pkg::vec3_t    acc_reg;
    lavm_pkg::unit3_t   z_reg;
    lavm_pkg::unit3_t   x_reg;
    lavm_pkg::unit3_t   y_reg;
    lavm_pkg::word3_t   t_reg;
    lavm_pkg::vec_t     p_reg;

    lavm_pkg::unit3_t   ox_reg;
    lavm_pkg::unit3_t   oy_reg;
    lavm_pkg::unit3_t   oz_reg;
    lavm_pkg::word3_t   ot_reg;
    logic               busy_reg;
    logic [1:0]         beat_reg;

    logic               norm_start;
    logic               norm_done;
    lavm_pkg::unit3_t   norm_unit;

    logic [1:0]         ai;
    logic [1:0]         bi;
    logic [1:0]         pc;
    lavm_pkg::word_t    a_op;
    lavm_pkg::unit_t    b_op;
    lavm_pkg::vec_t     prod;
    lavm_pkg::unit3_t   dot_vec;

    lavm_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .vec   (acc_reg),
        .done  (norm_done),
        .unit  (norm_unit)
    );

    assign norm_start = (state_reg == B_Z_GO) || (state_reg == B_X_GO) ||
                        (state_reg == B_Y_GO);
    assign q_pop      = (state_reg == B_IDLE) && q_valid;
    assign out_valid  = busy_reg;

    always_comb
    begin
        ai = lavm_pkg::cross_a_idx(step_reg);
        bi = lavm_pkg::cross_b_idx(step_reg);
        pc = 2'((step_reg - 3'd1) >> 1);
        case (dot_reg)
            2'd0:    dot_vec = x_reg;
            2'd1:    dot_vec = y_reg;
            default: dot_vec = z_reg;
        endcase
        case (state_reg)
            B_XR:
            begin
                a_op = up_reg[ai];
                b_op = z_reg[bi];
            end
            B_YR:
            begin
                a_op = {{(lavm_pkg::WW-lavm_pkg::UW){z_reg[ai][lavm_pkg::UW-1]}}, z_reg[ai]};
                b_op = x_reg[bi];
            end
            default:
            begin
                a_op = eye_reg[step_reg[1:0]];
                b_op = dot_vec[step_reg[1:0]];
            end
        endcase
        prod = a_op * b_op;
    end

    always_comb
    begin
        out_data.column_index = beat_reg;
        out_data.last_beat    = (beat_reg == lavm_pkg::LAST_COL);
        if (beat_reg == lavm_pkg::LAST_COL)
        begin
            out_data.row0_value = ot_reg[0];
            out_data.row1_value = ot_reg[1];
            out_data.row2_value = ot_reg[2];
            out_data.row3_value = lavm_pkg::word_t'(lavm_pkg::ONE_Q16);
        end
        else
        begin
            out_data.row0_value = lavm_pkg::word_t'(ox_reg[beat_reg]);
            out_data.row1_value = lavm_pkg::word_t'(oy_reg[beat_reg]);
            out_data.row2_value = lavm_pkg::word_t'(oz_reg[beat_reg]);
            out_data.row3_value = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            step_reg  <= 3'd0;
            dot_reg   <= 2'd0;
            busy_reg  <= 1'b0;
            beat_reg  <= 2'd0;
        end
        else
        begin
            if (busy_reg && out_ready)
            begin
                if (beat_reg == lavm_pkg::LAST_COL)
                begin
                    busy_reg <= 1'b0;
                    beat_reg <= 2'd0;
                end
                else
                begin
                    beat_reg <= beat_reg + 2'd1;
                end
            end

            unique case (state_reg)
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        eye_reg <= q_item.eye;
                        up_reg  <= q_item.up;
                        for (int i = 0; i < 3; i++)
                        begin
                            acc_reg[i] <= lavm_pkg::vec_t'(q_item.dir[i]);
                        end
                        state_reg <= B_Z_GO;
                    end
                end
                B_Z_GO:   state_reg <= B_Z_WAIT;
                B_X_GO:   state_reg <= B_X_WAIT;
                B_Y_GO:   state_reg <= B_Y_WAIT;
                B_Z_WAIT:
                begin
                    if (norm_done)
                    begin
                        z_reg     <= norm_unit;
                        step_reg  <= 3'd0;
                        state_reg <= B_XR;
                    end
                end
                B_X_WAIT:
                begin
                    if (norm_done)
                    begin
                        x_reg     <= norm_unit;
                        step_reg  <= 3'd0;
                        state_reg <= B_YR;
                    end
                end
                B_Y_WAIT:
                begin
                    if (norm_done)
                    begin
                        y_reg     <= norm_unit;
                        step_reg  <= 3'd0;
                        dot_reg   <= 2'd0;
                        state_reg <= B_DOT;
                    end
                end
                B_XR, B_YR:
                begin
                    // product issued one step, folded into its component the next
                    if (step_reg < 3'd6)
                    begin
                        p_reg <= prod;
                    end
                    if (step_reg != 3'd0)
                    begin
                        if (!step_reg[0])
                        begin
                            acc_reg[pc] <= acc_reg[pc] - p_reg;
                        end
                        else
                        begin
                            acc_reg[pc] <= p_reg;
                        end
                    end
                    if (step_reg == 3'd6)
                    begin
                        step_reg  <= 3'd0;
                        state_reg <= (state_reg == B_XR) ? B_X_GO : B_Y_GO;
                    end
                    else
                    begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                B_DOT:
                begin
                    if (step_reg < 3'd3)
                    begin
                        p_reg <= prod;
                    end
                    if (step_reg == 3'd1)
                    begin
                        acc_reg[0] <= p_reg;
                    end
                    else if (step_reg == 3'd2 || step_reg == 3'd3)
                    begin
                        acc_reg[0] <= acc_reg[0] + p_reg;
                    end
                    if (step_reg == 3'd4)
                    begin
                        t_reg[dot_reg] <= lavm_pkg::round_sat(acc_reg[0]);
                        step_reg       <= 3'd0;
                        if (dot_reg == 2'd2)
                        begin
                            state_reg <= B_FIN;
                        end
                        else
                        begin
                            dot_reg <= dot_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                B_FIN:
                begin
                    if (!busy_reg)
                    begin
                        ox_reg    <= x_reg;
                        oy_reg    <= y_reg;
                        oz_reg    <= z_reg;
                        ot_reg    <= t_reg;
                        busy_reg  <= 1'b1;
                        beat_reg  <= 2'd0;
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/look_at_view_matrix_core.sv @@
// Top level of the look-at view matrix core.
// Each request (eye, target, up in signed Q16.16) yields one column-major view matrix as four
// column beats, column 0 first, last_beat on column 3. Three vector normalizations dominate.
// Each one runs a block shift of up to 29 steps, a 31-step bit-serial square root and three
// 18-step restoring divides. Cross and dot products follow on one shared 32x18 multiplier.
// A zero-length vector skips its normalization, so a degenerate request (eye on target, or up
// zero or along the view line) can finish early. Up to two requests queue in front of the
// sequencer, and a finished matrix waits in its own result buffer, so the next request is
// computed while the previous beats drain.
module look_at_view_matrix_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  lavm_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output lavm_pkg::out_t  out_data
);

    logic            q_valid;
    logic            q_pop;
    lavm_pkg::item_t q_item;

    lavm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    lavm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ src/lavm_checker.sv @@
// Port-level checks on the matrix beat stream, bound to the top level.
module lavm_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            out_valid,
    input logic            out_ready,
    input lavm_pkg::out_t  out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    a_beats_follow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_beat |=> out_valid &&
        (out_data.column_index == $past(out_data.column_index) + 2'd1))
        else $error("matrix columns not sent in order");

    a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last_beat == (out_data.column_index == lavm_pkg::LAST_COL)))
        else $error("last_beat does not mark column 3");

    a_row3: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.row3_value == ((out_data.column_index == lavm_pkg::LAST_COL)
            ? lavm_pkg::word_t'(lavm_pkg::ONE_Q16) : lavm_pkg::word_t'(0))))
        else $error("bottom row is not 0 0 0 1");

endmodule

bind look_at_view_matrix_core lavm_checker u_lavm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

@@ verif/tb_look_at_view_matrix_core.sv @@
// Self-checking testbench for the look-at view matrix core.
`timescale 1ns / 100ps

module tb_look_at_view_matrix_core;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 3000;
    localparam int TAIL_CYCLES    = 600;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    lavm_pkg::in_t  in_data;
    logic           out_valid;
    logic           out_ready;
    lavm_pkg::out_t out_data;

    lavm_pkg::out_t column_q[$];
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_req;
    int   held_cycles;
    int   errors;
    int   quiet_cycles;

    look_at_view_matrix_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------- view matrix prediction ----------------

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // scale a 3-vector to Q16.16 unit length; an all-zero vector stays zero
    function automatic void unit_vector(input longint v[3], output longint u[3]);
        longint unsigned a[3];
        longint unsigned m;
        longint unsigned sum;
        longint unsigned mag;
        longint unsigned q;
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = (v[i] < 0) ? -v[i] : v[i];
            if (a[i] > m) m = a[i];
        end
        if (m == 0)
        begin
            u[0] = 0; u[1] = 0; u[2] = 0;
            return;
        end
        while (m >= (64'd1 << 30))
        begin
            m >>= 1;
            for (int i = 0; i < 3; i++) a[i] >>= 1;
        end
        while (m < (64'd1 << 29))
        begin
            m <<= 1;
            for (int i = 0; i < 3; i++) a[i] <<= 1;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) sum += a[i] * a[i];
        mag = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q    = ((a[i] << 16) + (mag >> 1)) / mag;
            u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
    endfunction

    // negated Q32.32 dot product, round half up, saturate to a word
    function automatic lavm_pkg::word_t eye_offset(input longint r[3], input longint e[3]);
        longint s;
        s = -(r[0] * e[0] + r[1] * e[1] + r[2] * e[2]);
        s = (s + 32768) >>> 16;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return lavm_pkg::word_t'(s);
    endfunction

    task automatic predict_view(input lavm_pkg::in_t v);
        longint e[3], up[3], d[3], fz[3], sx[3], ux[3], cy[3], uy[3];
        lavm_pkg::out_t col;
        e[0]  = v.eye_x; e[1] = v.eye_y; e[2] = v.eye_z;
        up[0] = v.up_x;  up[1] = v.up_y; up[2] = v.up_z;
        d[0]  = e[0] - longint'(v.target_x);
        d[1]  = e[1] - longint'(v.target_y);
        d[2]  = e[2] - longint'(v.target_z);
        unit_vector(d, fz);
        sx[0] = up[1] * fz[2] - up[2] * fz[1];
        sx[1] = up[2] * fz[0] - up[0] * fz[2];
        sx[2] = up[0] * fz[1] - up[1] * fz[0];
        unit_vector(sx, ux);
        cy[0] = fz[1] * ux[2] - fz[2] * ux[1];
        cy[1] = fz[2] * ux[0] - fz[0] * ux[2];
        cy[2] = fz[0] * ux[1] - fz[1] * ux[0];
        unit_vector(cy, uy);
        for (int c = 0; c < 3; c++)
        begin
            col.column_index = 2'(c);
            col.row0_value   = lavm_pkg::word_t'(ux[c]);
            col.row1_value   = lavm_pkg::word_t'(uy[c]);
            col.row2_value   = lavm_pkg::word_t'(fz[c]);
            col.row3_value   = '0;
            col.last_beat    = 1'b0;
            column_q.push_back(col);
        end
        col.column_index = lavm_pkg::LAST_COL;
        col.row0_value   = eye_offset(ux, e);
        col.row1_value   = eye_offset(uy, e);
        col.row2_value   = eye_offset(fz, e);
        col.row3_value   = lavm_pkg::word_t'(lavm_pkg::ONE_Q16);
        col.last_beat    = 1'b1;
        column_q.push_back(col);
    endtask

    // ---------------- request side ----------------

    // called at a falling edge, returns at a falling edge
    task automatic send_view(input lavm_pkg::in_t v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_view(v);
        @(negedge clk);
    endtask

    function automatic lavm_pkg::in_t make_view(input lavm_pkg::word_t ex, ey, ez, tx, ty, tz,
                                                ux, uy, uz);
        lavm_pkg::in_t v;
        v.eye_x = ex; v.eye_y = ey; v.eye_z = ez;
        v.target_x = tx; v.target_y = ty; v.target_z = tz;
        v.up_x = ux; v.up_y = uy; v.up_z = uz;
        return v;
    endfunction

    function automatic lavm_pkg::word_t rand_word(input int shape);
        logic signed [19:0] s20;
        lavm_pkg::word_t    w;
        w   = $urandom;
        s20 = 20'($urandom);
        case (shape)
            0:       return w;
            1:       return lavm_pkg::word_t'(s20);
            default: return lavm_pkg::word_t'($signed(w) >>> $urandom_range(31));
        endcase
    endfunction

    function automatic lavm_pkg::in_t rand_view();
        lavm_pkg::in_t v;
        int  shape;
        int  kind;
        shape = $urandom_range(2);
        kind  = $urandom_range(9);
        v = make_view(rand_word(shape), rand_word(shape), rand_word(shape),
                      rand_word(shape), rand_word(shape), rand_word(shape),
                      rand_word(shape), rand_word(shape), rand_word(shape));
        if (kind == 0)
        begin
            // eye on target
            v.target_x = v.eye_x; v.target_y = v.eye_y; v.target_z = v.eye_z;
        end
        else if (kind == 1)
        begin
            // up along the view line
            v.up_x = v.eye_x - v.target_x;
            v.up_y = v.eye_y - v.target_y;
            v.up_z = v.eye_z - v.target_z;
        end
        else if (kind == 2)
        begin
            v.up_x = '0; v.up_y = '0; v.up_z = '0;
        end
        return v;
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (column_q.size() != 0) @(negedge clk);
    endtask

    // ---------------- tests ----------------

    task automatic test_directed();
        lavm_pkg::word_t mx, mn, one;
        mx  = 32'sh7fffffff;
        mn  = 32'sh80000000;
        one = 32'sh00010000;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_view(make_view(0, 0, 5 * one, 0, 0, 0, 0, one, 0));
        send_view(make_view(one, 2 * one, 3 * one, -one, 0, one, 0, 0, one));
        send_view(make_view(mx, mx, mx, mn, mn, mn, mx, mn, mx));
        send_view(make_view(mn, mn, mn, mx, mx, mx, mn, mx, mn));
        send_view(make_view(mx, mn, mx, mn, mx, mn, 1, 1, 1));
        send_view(make_view(mx, 0, 0, mn, 0, 0, 0, mn, 0));
        send_view(make_view(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_view(make_view(one, one, one, one, one, one, 0, one, 0));
        send_view(make_view(0, 0, one, 0, 0, 0, 0, 0, 7 * one));
        send_view(make_view(0, 0, one, 0, 0, 0, 0, 0, 0));
        send_view(make_view(1, 0, 0, 0, 0, 0, 0, 1, 0));
        send_view(make_view(mx, mx, mx, mx - 1, mx, mx, 0, 0, mx));
        send_view(make_view(mn, mn, mn, mn, mn, mn + 1, mn, 0, 0));
        send_view(make_view(-one, -one, -one, one, one, one, -one, one, -one));
        send_view(make_view(mx, mx, mx, 0, 0, 0, mx, mn, 0));
        send_view(make_view(mn, mx, mn, 0, 0, 0, 1, -1, 1));
        send_view(make_view(3, -7, 11, -5, 2, 9, -1, -1, -1));
        send_view(make_view(32'sh00008000, 0, 0, 0, 0, 0, 0, 0, -1));
        wait_drained();
    endtask

    task automatic test_long_hold();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b1;
        for (int i = 0; i < 8; i++) send_view(rand_view());
        in_valid <= 1'b0;
        @(negedge clk);
        while (held_cycles < HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        wait_drained();
    endtask

    task automatic test_drain_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 20;
        for (int i = 0; i < 6; i++) send_view(rand_view());
        wait_drained();
        for (int i = 0; i < 6; i++) send_view(rand_view());
    endtask

    task automatic test_random(input int send_pct, input int recv_pct, input int count);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < count; i++) send_view(rand_view());
    endtask

    // ---------------- result side ----------------

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_req && held_cycles < HOLD_CYCLES)
        begin
            held_cycles <= held_cycles + 1;
            out_ready   <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        lavm_pkg::out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (column_q.size() == 0)
            begin
                $error("column beat with no request pending");
                errors++;
            end
            else
            begin
                want = column_q.pop_front();
                if (out_data.column_index !== want.column_index)
                begin
                    $error("column_index: expected %0d, got %0d",
                           want.column_index, out_data.column_index);
                    errors++;
                end
                if (out_data.row0_value !== want.row0_value)
                begin
                    $error("row0_value: expected %0d, got %0d",
                           want.row0_value, out_data.row0_value);
                    errors++;
                end
                if (out_data.row1_value !== want.row1_value)
                begin
                    $error("row1_value: expected %0d, got %0d",
                           want.row1_value, out_data.row1_value);
                    errors++;
                end
                if (out_data.row2_value !== want.row2_value)
                begin
                    $error("row2_value: expected %0d, got %0d",
                           want.row2_value, out_data.row2_value);
                    errors++;
                end
                if (out_data.row3_value !== want.row3_value)
                begin
                    $error("row3_value: expected %0d, got %0d",
                           want.row3_value, out_data.row3_value);
                    errors++;
                end
                if (out_data.last_beat !== want.last_beat)
                begin
                    $error("last_beat: expected %0d, got %0d",
                           want.last_beat, out_data.last_beat);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_look_at_view_matrix_core: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        hold_req       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_long_hold();
        test_drain_pause();
        test_random(0, 0, 110);
        test_random(56, 0, 110);
        test_random(0, 56, 110);
        test_random(27, 27, 110);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && column_q.size() == 0)
        begin
            $display("tb_look_at_view_matrix_core: done, clean");
        end
        else
        begin
            $display("tb_look_at_view_matrix_core: done, errors");
        end
        $finish;
    end

endmodule
